[rtl/time_window_rolling_mean_unit_assert.svh]
// Assertion macros shared by the rolling mean RTL.
`ifndef TIME_WINDOW_ROLLING_MEAN_UNIT_ASSERT_SVH
`define TIME_WINDOW_ROLLING_MEAN_UNIT_ASSERT_SVH

// Invariant that holds at every clock edge out of reset.
`define TWRM_ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// Same-cycle implication.
`define TWRM_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// Next-cycle implication.
`define TWRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

[rtl/twrm_pkg.sv]
// Types and fixed widths of the time-windowed rolling mean.
package twrm_pkg;

  localparam int TIME_W     = 48;
  localparam int PCT_W      = 14;
  localparam int BYTES_W    = 48;
  localparam int WIN_W      = 20;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 80;

  localparam logic [WIN_W-1:0] WINDOW_MS_RESET = 20'd3000;

  localparam int DIV_LANES  = 3;
  localparam int LANE_CPU   = 0;
  localparam int LANE_MEM   = 1;
  localparam int LANE_BYTES = 2;

  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  time_ms;
    logic [PCT_W-1:0]   cpu_pct;
    logic [PCT_W-1:0]   mem_pct;
    logic [BYTES_W-1:0] mem_bytes;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/time_window_rolling_mean_unit.sv]
// Top level of the time-windowed rolling mean over usage samples.
//
// Each accepted sample beat first evicts, oldest first, stored entries more
// than window_ms older than its timestamp, drops the oldest entry if the store
// is full, appends itself and returns one beat with the truncated means of the
// valid entries kept. Entries live in a single synchronous memory walked from
// the oldest slot, one slot per cycle; running sums and counts sit in flops.
// The eviction walk reads the stored entries that are evicted plus the one
// that stops the walk, if any remain. The walk runs over the memory read port.
// The one-bit-per-cycle divider forms all three means at once over the width
// of the byte sum, 48 bits plus the ceiling of log2 of WINDOW_DEPTH; a sample
// that leaves no valid entry skips it. The next sample is taken while the
// result beat still waits in the output register; its own result then holds
// until that register frees. No clearing pass is needed after reset.
module time_window_rolling_mean_unit #(
  parameter int WINDOW_DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [twrm_pkg::WIN_W-1:0]        cfg_data,     // window_ms
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // time_ms[47:0], cpu_pct[61:48], mem_pct[75:62], mem_bytes[123:76], zero pad
  input  logic [twrm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                              s_axis_tuser, // sample_valid
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mean_cpu_pct[13:0], mean_mem_pct[27:14], mean_mem_bytes[75:28], zero pad
  output logic [twrm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                              m_axis_tuser  // mean_valid
);
  import twrm_pkg::*;

`include "time_window_rolling_mean_unit_assert.svh"

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int TAIL_W = CNT_W + 1;
  localparam int CS_W   = PCT_W + PTR_W;
  localparam int BS_W   = BYTES_W + PTR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_APPEND,
    S_DIVIDE,
    S_RESULT
  } state_t;

  state_t             state;
  logic [WIN_W-1:0]   window_ms;
  logic [PTR_W-1:0]   head_slot;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   valid_count;
  logic [CS_W-1:0]    cpu_sum;
  logic [CS_W-1:0]    mem_pct_sum;
  logic [BS_W-1:0]    bytes_sum;
  entry_t             samp;

  logic               in_beat;
  entry_t             rd;
  logic               mem_re;
  logic [PTR_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [PTR_W-1:0]   tail_slot;
  logic [TAIL_W-1:0]  tail_sum;
  logic [TAIL_W-1:0]  tail_wrap;

  logic [TIME_W-1:0]  age;
  logic               evict;
  logic               drop;
  logic               more;
  logic [PTR_W-1:0]   head_inc;
  logic [CNT_W-1:0]   fill_dec;

  logic [CNT_W-1:0]   valid_count_next;
  logic [CS_W-1:0]    cpu_sum_next;
  logic [CS_W-1:0]    mem_pct_sum_next;
  logic [BS_W-1:0]    bytes_sum_next;

  logic                         div_start;
  logic [DIV_LANES-1:0][BS_W-1:0] div_dvd;
  logic [DIV_LANES-1:0][BS_W-1:0] div_q;
  div_stat_t                    div_stat;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // Oldest-entry check on the word read last cycle.
  assign age      = samp.time_ms - rd.time_ms;
  assign evict    = (samp.time_ms >= rd.time_ms) && (age > TIME_W'(window_ms));
  assign drop     = (state == S_CHECK) &&
                    (evict || (fill_count == CNT_W'(WINDOW_DEPTH)));
  assign fill_dec = fill_count - 1'b1;
  assign more     = evict && (fill_dec != '0);
  assign head_inc = (head_slot == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : head_slot + 1'b1;

  assign mem_re    = (in_beat && (fill_count != '0)) || (drop && more);
  assign mem_raddr = (state == S_IDLE) ? head_slot : head_inc;

  assign tail_sum  = TAIL_W'(head_slot) + TAIL_W'(fill_count);
  assign tail_wrap = (tail_sum >= TAIL_W'(WINDOW_DEPTH)) ?
                     tail_sum - TAIL_W'(WINDOW_DEPTH) : tail_sum;
  assign tail_slot = tail_wrap[PTR_W-1:0];
  assign mem_we    = (state == S_APPEND);

  // Sums after the append of the held sample.
  always_comb begin
    valid_count_next = valid_count;
    cpu_sum_next     = cpu_sum;
    mem_pct_sum_next = mem_pct_sum;
    bytes_sum_next   = bytes_sum;
    if (samp.valid) begin
      valid_count_next = valid_count + 1'b1;
      cpu_sum_next     = cpu_sum + CS_W'(samp.cpu_pct);
      mem_pct_sum_next = mem_pct_sum + CS_W'(samp.mem_pct);
      bytes_sum_next   = bytes_sum + BS_W'(samp.mem_bytes);
    end
  end

  assign div_start              = (state == S_APPEND) && (valid_count_next != '0);
  assign div_dvd[LANE_CPU]      = BS_W'(cpu_sum_next);
  assign div_dvd[LANE_MEM]      = BS_W'(mem_pct_sum_next);
  assign div_dvd[LANE_BYTES]    = bytes_sum_next;

  twrm_mem #(
    .DEPTH (WINDOW_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (tail_slot),
    .wdata (samp),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  twrm_div #(
    .DW (BS_W),
    .CW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (valid_count_next),
    .dividend (div_dvd),
    .quot     (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_ms     <= WINDOW_MS_RESET;
      head_slot     <= '0;
      fill_count    <= '0;
      valid_count   <= '0;
      cpu_sum       <= '0;
      mem_pct_sum   <= '0;
      bytes_sum     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_ms <= cfg_data;
      end
      // The result state reloads the output register itself.
      if (m_axis_tvalid && m_axis_tready && (state != S_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            samp.valid     <= s_axis_tuser;
            samp.time_ms   <= s_axis_tdata[47:0];
            samp.cpu_pct   <= s_axis_tdata[61:48];
            samp.mem_pct   <= s_axis_tdata[75:62];
            samp.mem_bytes <= s_axis_tdata[123:76];
            state          <= (fill_count != '0) ? S_CHECK : S_APPEND;
          end
        end
        S_CHECK: begin
          if (drop) begin
            head_slot  <= head_inc;
            fill_count <= fill_dec;
            if (rd.valid) begin
              valid_count <= valid_count - 1'b1;
              cpu_sum     <= cpu_sum - CS_W'(rd.cpu_pct);
              mem_pct_sum <= mem_pct_sum - CS_W'(rd.mem_pct);
              bytes_sum   <= bytes_sum - BS_W'(rd.mem_bytes);
            end
          end
          // Keep walking while entries age out and some remain.
          state <= (drop && more) ? S_CHECK : S_APPEND;
        end
        S_APPEND: begin
          fill_count  <= fill_count + 1'b1;
          valid_count <= valid_count_next;
          cpu_sum     <= cpu_sum_next;
          mem_pct_sum <= mem_pct_sum_next;
          bytes_sum   <= bytes_sum_next;
          state       <= div_start ? S_DIVIDE : S_RESULT;
        end
        S_DIVIDE: begin
          if (div_stat.done) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          // Hold until the output register is free.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            if (valid_count != '0) begin
              m_axis_tuser         <= 1'b1;
              m_axis_tdata[13:0]   <= div_q[LANE_CPU][PCT_W-1:0];
              m_axis_tdata[27:14]  <= div_q[LANE_MEM][PCT_W-1:0];
              m_axis_tdata[75:28]  <= div_q[LANE_BYTES][BYTES_W-1:0];
            end else begin
              m_axis_tuser         <= 1'b0;
              m_axis_tdata[75:0]   <= '0;
            end
            m_axis_tdata[OUT_TDATA_W-1:76] <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TWRM_ASSERT_HOLDS(a_fill_bound, fill_count <= CNT_W'(WINDOW_DEPTH))
  `TWRM_ASSERT_HOLDS(a_valid_le_fill, valid_count <= fill_count)
  `TWRM_ASSERT_IMPLIES(a_empty_sums, valid_count == '0, (cpu_sum == '0) && (mem_pct_sum == '0) && (bytes_sum == '0))
  `TWRM_ASSERT_NEXT(a_div_launch, div_start, div_stat.busy && (state == S_DIVIDE))

endmodule

[rtl/twrm_mem.sv]
// Sample store: one-port-write, one-port-read synchronous memory.
module twrm_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  twrm_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output twrm_pkg::entry_t rdata
);
  import twrm_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/twrm_div.sv]
// Restoring divider, one quotient bit per cycle, lanes sharing one divisor.
module twrm_div #(
  parameter int DW = 54,
  parameter int CW = 7
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [CW-1:0]                         divisor,
  input  logic [twrm_pkg::DIV_LANES-1:0][DW-1:0] dividend,
  output logic [twrm_pkg::DIV_LANES-1:0][DW-1:0] quot,
  output twrm_pkg::div_stat_t                   stat
);
  import twrm_pkg::*;

  localparam int SW = $clog2(DW + 1);

  logic                          busy;
  logic                          done;
  logic [SW-1:0]                 cnt;
  logic [CW-1:0]                 dsr;
  logic [DIV_LANES-1:0][DW-1:0]  dvd;
  logic [DIV_LANES-1:0][CW-1:0]  rem;
  logic [DIV_LANES-1:0][CW:0]    rem_sh;
  logic [DIV_LANES-1:0]          ge;
  logic [DIV_LANES-1:0][CW:0]    rem_sub;

  always_comb begin
    for (int i = 0; i < DIV_LANES; i++) begin
      rem_sh[i]  = {rem[i], dvd[i][DW-1]};
      ge[i]      = rem_sh[i] >= {1'b0, dsr};
      rem_sub[i] = rem_sh[i] - {1'b0, dsr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= SW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend register shifts out its top bit and takes the quotient bit in.
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      for (int i = 0; i < DIV_LANES; i++) begin
        rem[i] <= ge[i] ? rem_sub[i][CW-1:0] : rem_sh[i][CW-1:0];
        dvd[i] <= {dvd[i][DW-2:0], ge[i]};
      end
    end
  end

  assign quot        = dvd;
  assign stat.busy   = busy;
  assign stat.done   = done;

endmodule

[dv/tb_time_window_rolling_mean_unit.sv]
// Testbench of the time-windowed rolling mean: directed table, then random phases per window.
`timescale 1ns / 1ps

module tb_time_window_rolling_mean_unit;
  import twrm_pkg::*;

  localparam int          DEPTH        = 64;
  localparam int unsigned CYCLE_LIMIT  = 1200000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned IDLE_CYCLES  = 8;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam logic [PCT_W-1:0]   PCT_MAX   = 14'd10000;
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
  localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};

  typedef struct packed {
    logic               mean_valid;
    logic [PCT_W-1:0]   mean_cpu;
    logic [PCT_W-1:0]   mean_mem;
    logic [BYTES_W-1:0] mean_bytes;
  } mean_t;

  typedef struct packed {
    entry_t smp;
    logic   typed;
    mean_t  want;
  } row_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS = 2'd0,
    RDY_COIN   = 2'd1,
    RDY_RARE   = 2'd2
  } rdy_mode_e;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [WIN_W-1:0]       cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  // predictor state
  entry_t        kept[$];
  bit [WIN_W-1:0] win_ms;
  bit [63:0]     valid_kept;
  bit [63:0]     cpu_total;
  bit [63:0]     mem_total;
  bit [63:0]     bytes_total;

  mean_t         mean_fifo[$];
  row_t          directed_rows[$];
  bit [TIME_W-1:0] stim_time;

  int unsigned   error_count = 0;
  int unsigned   result_count = 0;
  int unsigned   samples_accepted = 0;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 0;

  rdy_mode_e     rdy_mode = RDY_ALWAYS;
  int unsigned   mode_left = 0;
  int unsigned   hold_left = 0;
  bit            hold_done = 1'b0;

  time_window_rolling_mean_unit #(
    .WINDOW_DEPTH(DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void drop_oldest_entry();
    entry_t head;
    if (kept.size() > 0) begin
      head = kept.pop_front();
      if (head.valid) begin
        valid_kept  -= 1;
        cpu_total   -= head.cpu_pct;
        mem_total   -= head.mem_pct;
        bytes_total -= head.mem_bytes;
      end
    end
  endfunction

  function automatic void clear_window_store();
    kept.delete();
    win_ms      = WINDOW_MS_RESET;
    valid_kept  = 0;
    cpu_total   = 0;
    mem_total   = 0;
    bytes_total = 0;
  endfunction

  function automatic mean_t window_mean_step(entry_t s);
    mean_t  m;
    entry_t head;
    bit     aging;
    aging = 1'b1;
    // age out from the oldest end; an entry newer than the sample stays
    while (aging && kept.size() > 0) begin
      head = kept[0];
      if (s.time_ms >= head.time_ms && (s.time_ms - head.time_ms) > {28'd0, win_ms})
        drop_oldest_entry();
      else
        aging = 1'b0;
    end
    if (kept.size() >= DEPTH) drop_oldest_entry();
    kept.push_back(s);
    if (s.valid) begin
      valid_kept  += 1;
      cpu_total   += s.cpu_pct;
      mem_total   += s.mem_pct;
      bytes_total += s.mem_bytes;
    end
    m = '0;
    if (valid_kept != 0) begin
      m.mean_valid = 1'b1;
      m.mean_cpu   = PCT_W'(cpu_total / valid_kept);
      m.mean_mem   = PCT_W'(mem_total / valid_kept);
      m.mean_bytes = BYTES_W'(bytes_total / valid_kept);
    end
    return m;
  endfunction

  function automatic logic [PCT_W-1:0] rand_pct();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return PCT_MAX;
    if (r < 88) return PCT_W'($urandom_range(0, 10000));
    return PCT_W'($urandom_range(10001, 16383));
  endfunction

  function automatic entry_t next_sample();
    entry_t      s;
    int unsigned r;
    int unsigned span;
    span = win_ms;
    r = $urandom_range(99);
    if (r < 60)      stim_time += $urandom_range(0, span / 32 + 1);
    else if (r < 85) stim_time += $urandom_range(0, span + 2);
    else if (r < 93) stim_time += span + $urandom_range(0, 1);
    else if (r < 97) stim_time += $urandom;
    else             stim_time -= $urandom_range(0, span + 5);
    s.valid   = ($urandom_range(3) != 0);
    s.time_ms = stim_time;
    s.cpu_pct = rand_pct();
    s.mem_pct = rand_pct();
    r = $urandom_range(19);
    if (r == 0)      s.mem_bytes = '0;
    else if (r == 1) s.mem_bytes = BYTES_MAX;
    else             s.mem_bytes = BYTES_W'({$urandom, $urandom});
    return s;
  endfunction

  task automatic add_row(logic v, logic [TIME_W-1:0] t, logic [PCT_W-1:0] c,
                         logic [PCT_W-1:0] m, logic [BYTES_W-1:0] b, logic typed,
                         mean_t want);
    row_t r;
    r.smp.valid     = v;
    r.smp.time_ms   = t;
    r.smp.cpu_pct   = c;
    r.smp.mem_pct   = m;
    r.smp.mem_bytes = b;
    r.typed         = typed;
    r.want          = want;
    directed_rows.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
               result_count, what, got, want);
  endtask

  // Drive one sample beat, with a random gap between bursts; push the mean on accept.
  task automatic send_sample(entry_t s, mean_t predicted);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= s.valid;
    s_axis_tdata  <= {4'd0, s.mem_bytes, s.mem_pct, s.cpu_pct, s.time_ms};
    do @(posedge clk); while (!s_axis_tready);
    mean_fifo.push_back(predicted);
    samples_accepted++;
  endtask

  // Write window_ms once the block has drained.
  task automatic set_window(logic [WIN_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (mean_fifo.size() > 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    win_ms = value;
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    mean_t got;
    mean_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.mean_valid = m_axis_tuser;
      got.mean_cpu   = m_axis_tdata[13:0];
      got.mean_mem   = m_axis_tdata[27:14];
      got.mean_bytes = m_axis_tdata[75:28];
      if (mean_fifo.size() == 0) begin
        report_mismatch("unexpected beat, tdata", 64'(m_axis_tdata), 64'd0);
      end else begin
        want = mean_fifo.pop_front();
        if (got.mean_valid !== want.mean_valid)
          report_mismatch("mean_valid", 64'(got.mean_valid), 64'(want.mean_valid));
        if (got.mean_cpu !== want.mean_cpu)
          report_mismatch("mean_cpu_pct", 64'(got.mean_cpu), 64'(want.mean_cpu));
        if (got.mean_mem !== want.mean_mem)
          report_mismatch("mean_mem_pct", 64'(got.mean_mem), 64'(want.mean_mem));
        if (got.mean_bytes !== want.mean_bytes)
          report_mismatch("mean_mem_bytes", 64'(got.mean_bytes), 64'(want.mean_bytes));
      end
      result_count++;
    end
  end

  // receiver stall pattern, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && samples_accepted >= HOLD_AT) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  <= rdy_mode_e'($urandom_range(2));
        mode_left <= $urandom_range(10, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rdy_mode)
        RDY_ALWAYS: m_axis_tready <= 1'b1;
        RDY_COIN:   m_axis_tready <= 1'($urandom_range(1));
        default:    m_axis_tready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    mean_t       predicted;
    mean_t       none;
    logic [WIN_W-1:0] phase_win[6];
    clear_window_store();
    none = '0;

    // window 3000 after reset
    add_row(1'b0, '0, '0, '0, '0, 1'b1, '{1'b0, '0, '0, '0});
    add_row(1'b1, '0, PCT_MAX, PCT_MAX, BYTES_MAX, 1'b1,
            '{1'b1, PCT_MAX, PCT_MAX, BYTES_MAX});
    add_row(1'b1, 48'd3000, '0, '0, '0, 1'b1,
            '{1'b1, 14'd5000, 14'd5000, 48'h7FFF_FFFF_FFFF});
    add_row(1'b1, 48'd3001, 14'h3FFF, 14'h3FFF, 48'd1, 1'b0, none);
    add_row(1'b0, 48'd2000, 14'd1234, 14'd4321, 48'd999, 1'b0, none);
    add_row(1'b1, 48'd5001, 14'd1, 14'd2, 48'd3, 1'b0, none);
    add_row(1'b1, 48'd5002, 14'd9999, 14'd7, 48'h1234_5678_9ABC, 1'b0, none);
    add_row(1'b1, 48'd100000, 14'd2500, 14'd7500, 48'd4096, 1'b0, none);
    add_row(1'b0, 48'd200000, 14'd8000, 14'd8000, 48'd8, 1'b1, '{1'b0, '0, '0, '0});
    add_row(1'b0, 48'd201000, 14'd10, 14'd20, 48'd30, 1'b1, '{1'b0, '0, '0, '0});
    add_row(1'b1, TIME_MAX - 48'd3000, 14'd100, 14'd200, BYTES_MAX, 1'b0, none);
    add_row(1'b1, TIME_MAX, 14'd300, 14'd400, BYTES_MAX, 1'b0, none);
    add_row(1'b1, '0, 14'd10000, 14'd0, 48'd0, 1'b0, none);
    add_row(1'b1, 48'd1, 14'd0, 14'd10000, BYTES_MAX, 1'b0, none);

    phase_win[0] = '0;
    phase_win[1] = {WIN_W{1'b1}};
    phase_win[2] = 20'd1;
    phase_win[3] = 20'd250;
    phase_win[4] = WIN_W'($urandom_range(0, 1048575));
    phase_win[5] = WINDOW_MS_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      predicted = window_mean_step(directed_rows[i].smp);
      if (directed_rows[i].typed) predicted = directed_rows[i].want;
      send_sample(directed_rows[i].smp, predicted);
    end

    foreach (phase_win[p]) begin
      set_window(phase_win[p]);
      stim_time = TIME_W'({$urandom, $urandom});
      repeat (PHASE_ITEMS) begin
        entry_t smp;
        smp = next_sample();
        predicted = window_mean_step(smp);
        send_sample(smp, predicted);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (mean_fifo.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/twrm_pkg.sv
rtl/twrm_mem.sv
rtl/twrm_div.sv
rtl/time_window_rolling_mean_unit.sv
dv/tb_time_window_rolling_mean_unit.sv
